>>> sv/sgh_pkg.sv
package sgh_pkg;

  // Field widths of the items and registers.
  localparam int MODE_W   = 2;
  localparam int CELL_W   = 6;
  localparam int SAMPLE_W = 12;
  localparam int OCC_W    = 2;
  localparam int TRIG_W   = 12;
  localparam int ALPHA_W  = 8;
  localparam int SUM_W    = 23;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;

  // Divider geometry: a 24-bit dividend, a 13-bit divisor and a
  // 12-bit quotient, two quotient bits resolved in each stage.
  localparam int DVD_W          = 24;
  localparam int DIV_W          = 13;
  localparam int STEPS_PER_STAGE = 2;
  localparam int DIV_STAGES     = SAMPLE_W / STEPS_PER_STAGE;

  localparam int RELEASE_GAP = 10;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

  // Item modes.
  localparam logic [MODE_W-1:0] MODE_DETECT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ACCUM  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FINISH = 2'd2;

  // Occupancy codes.
  localparam logic [OCC_W-1:0] OCC_NONE = 2'd0;
  localparam logic [OCC_W-1:0] OCC_POS  = 2'd1;
  localparam logic [OCC_W-1:0] OCC_NEG  = 2'd2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA   = 1'd1;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [CELL_W-1:0]   cell_index;
    logic [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [CELL_W-1:0]   cell_out;
    logic [OCC_W-1:0]    cell_state;
    logic [SAMPLE_W-1:0] smoothed;
    logic [SAMPLE_W-1:0] baseline;
  } out_item_t;

  typedef struct packed {
    logic [TRIG_W-1:0]  set_level;
    logic [ALPHA_W-1:0] alpha_divisor;
  } cfg_t;

  // Everything that is kept for one cell.
  typedef struct packed {
    logic [SAMPLE_W-1:0] avg;
    logic [SAMPLE_W-1:0] base;
    logic [OCC_W-1:0]    occ;
    logic [SUM_W-1:0]    sum;
  } rec_t;

  // What travels with an item through the divider.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CELL_W-1:0] cell_idx;
    rec_t              rec;
    logic              clamp;
  } tag_t;

  // Partial state of the long division.
  typedef struct packed {
    logic [DIV_W-1:0]    rem;
    logic [SAMPLE_W-1:0] lo;
    logic [SAMPLE_W-1:0] q;
  } div_st_t;

  // Front queue head as seen by the back part.
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } head_t;

  // One restoring division step: brings in the next dividend bit.
  function automatic div_st_t div_step(div_st_t st, logic [DIV_W-1:0] dv);
    logic [DIV_W:0] sh;
    div_st_t        nx;
    sh = {st.rem, st.lo[SAMPLE_W-1]};
    nx.lo = {st.lo[SAMPLE_W-2:0], 1'b0};
    if (sh >= {1'b0, dv}) begin
      nx.rem = DIV_W'(sh - {1'b0, dv});
      nx.q   = {st.q[SAMPLE_W-2:0], 1'b1};
    end else begin
      nx.rem = sh[DIV_W-1:0];
      nx.q   = {st.q[SAMPLE_W-2:0], 1'b0};
    end
    return nx;
  endfunction

  // Factory baseline of each cell, repeating every 64 cells.
  function automatic logic [SAMPLE_W-1:0] default_baseline(logic [CELL_W-1:0] i);
    logic [SAMPLE_W-1:0] v;
    case (i)
      6'd0: v = 12'd2062;  6'd1: v = 12'd1972;  6'd2: v = 12'd2033;  6'd3: v = 12'd1975;
      6'd4: v = 12'd1972;  6'd5: v = 12'd1993;  6'd6: v = 12'd2005;  6'd7: v = 12'd2013;
      6'd8: v = 12'd2013;  6'd9: v = 12'd1952;  6'd10: v = 12'd1950; 6'd11: v = 12'd1971;
      6'd12: v = 12'd2000; 6'd13: v = 12'd1993; 6'd14: v = 12'd1931; 6'd15: v = 12'd2063;
      6'd16: v = 12'd2042; 6'd17: v = 12'd1936; 6'd18: v = 12'd1996; 6'd19: v = 12'd2013;
      6'd20: v = 12'd1940; 6'd21: v = 12'd2053; 6'd22: v = 12'd1946; 6'd23: v = 12'd1973;
      6'd24: v = 12'd2020; 6'd25: v = 12'd2040; 6'd26: v = 12'd2035; 6'd27: v = 12'd2047;
      6'd28: v = 12'd2035; 6'd29: v = 12'd1947; 6'd30: v = 12'd1986; 6'd31: v = 12'd2004;
      6'd32: v = 12'd1948; 6'd33: v = 12'd1992; 6'd34: v = 12'd1984; 6'd35: v = 12'd2037;
      6'd36: v = 12'd1976; 6'd37: v = 12'd1960; 6'd38: v = 12'd2017; 6'd39: v = 12'd1937;
      6'd40: v = 12'd1945; 6'd41: v = 12'd1940; 6'd42: v = 12'd1955; 6'd43: v = 12'd2040;
      6'd44: v = 12'd2027; 6'd45: v = 12'd2024; 6'd46: v = 12'd1982; 6'd47: v = 12'd1969;
      6'd48: v = 12'd1974; 6'd49: v = 12'd1963; 6'd50: v = 12'd1943; 6'd51: v = 12'd1977;
      6'd52: v = 12'd1980; 6'd53: v = 12'd1972; 6'd54: v = 12'd1986; 6'd55: v = 12'd2035;
      6'd56: v = 12'd2063; 6'd57: v = 12'd1960; 6'd58: v = 12'd1957; 6'd59: v = 12'd1958;
      6'd60: v = 12'd1987; 6'd61: v = 12'd2043; 6'd62: v = 12'd2027; 6'd63: v = 12'd1929;
      default: v = 12'd2000;
    endcase
    return v;
  endfunction

endpackage

>>> sv/sgh_front.sv
module sgh_front
  import sgh_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  input  logic     pop,
  output head_t    head
);

  localparam int QD  = 4;
  localparam int PW  = $clog2(QD);

  in_item_t       q_mem [QD];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [PW:0]    count;
  logic           push;

  // The queue refuses items only when every slot is taken.
  assign in_stall = (count == (PW+1)'(QD));
  assign push     = in_valid && !in_stall;

  assign head.valid = (count != '0);
  assign head.item  = q_mem[rd_ptr];

  // Slot storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= in_item;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> sv/sgh_back.sv
module sgh_back
  import sgh_pkg::*;
#(
  parameter int CELLS     = 64,
  parameter int CAL_SCANS = 2000
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  head_t     head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int IW = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int NCELL = 1 << CELL_W;
  localparam logic [DVD_W:0] CLAMP_LIM = (DVD_W+1)'(CAL_SCANS * (1 << SAMPLE_W));
  localparam logic [DIV_W-1:0] CAL_DIV = DIV_W'(CAL_SCANS);

  // Cell index wrapped into the grid, worked out at elaboration.
  logic [CELL_W-1:0] wrap_tab [NCELL];
  for (genvar g = 0; g < NCELL; g++) begin : g_wrap
    assign wrap_tab[g] = CELL_W'(g % CELLS);
  end

  // Per-cell store with a written flag for each entry.
  rec_t       mem [CELLS];
  logic       cell_vld [CELLS];

  logic              adv;
  logic              issue;
  logic              hazard;
  logic [CELL_W-1:0] iss_cell;

  logic              s1_v;
  in_item_t          s1_item;
  logic [CELL_W-1:0] s1_cell;
  rec_t              rd_rec;
  logic              rd_vld;

  logic              s2_v;
  tag_t              s2_tag;
  div_st_t           s2_st;
  logic [DIV_W-1:0]  s2_div;

  logic              d_v   [DIV_STAGES];
  tag_t              d_tag [DIV_STAGES];
  div_st_t           d_st  [DIV_STAGES];
  logic [DIV_W-1:0]  d_div [DIV_STAGES];
  logic [CELL_W-1:0] d_cell [DIV_STAGES];

  // The whole pipe moves unless a finished item waits at the output.
  assign adv      = !(out_valid && out_stall);
  assign iss_cell = wrap_tab[head.item.cell_index];

  // An item may not start while an earlier item for the same cell is in flight.
  always_comb begin
    hazard = (s1_v && s1_cell == iss_cell) || (s2_v && s2_tag.cell_idx == iss_cell);
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (d_v[k] && d_cell[k] == iss_cell) begin
        hazard = 1'b1;
      end
    end
  end

  assign issue = adv && head.valid && !hazard;
  assign pop   = issue;

  // Stage one: registered read of the cell store.
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_rec  <= mem[IW'(iss_cell)];
      rd_vld  <= cell_vld[IW'(iss_cell)];
      s1_item <= head.item;
      s1_cell <= iss_cell;
    end
  end

  // Current record of the cell, or its reset value if never written.
  rec_t                cur;
  logic [ALPHA_W-1:0]  n_eff;
  logic [19:0]         prod;
  logic [DVD_W-1:0]    dvd;
  logic [DIV_W-1:0]    dvs;
  logic [SUM_W:0]      acc;
  tag_t                s1_tag;

  always_comb begin
    if (rd_vld) begin
      cur = rd_rec;
    end else begin
      cur.avg  = '0;
      cur.base = default_baseline(s1_cell);
      cur.occ  = OCC_NONE;
      cur.sum  = '0;
    end
    n_eff = (cfg.alpha_divisor == '0) ? ALPHA_W'(1) : cfg.alpha_divisor;
    prod  = {12'd0, n_eff - 1'b1} * {8'd0, cur.avg};
    acc   = {1'b0, cur.sum} + (SUM_W+1)'(s1_item.sample);

    s1_tag.mode     = s1_item.mode;
    s1_tag.cell_idx = s1_cell;
    s1_tag.rec      = cur;
    s1_tag.clamp    = ({1'b0, DVD_W'(cur.sum)} >= CLAMP_LIM);
    dvd = '0;
    dvs = DIV_W'(1);
    case (s1_item.mode)
      MODE_DETECT: begin
        dvd = DVD_W'(prod) + DVD_W'(s1_item.sample);
        dvs = DIV_W'(n_eff);
      end
      MODE_ACCUM: begin
        s1_tag.rec.sum = acc[SUM_W] ? {SUM_W{1'b1}} : acc[SUM_W-1:0];
      end
      MODE_FINISH: begin
        dvd = DVD_W'(cur.sum);
        dvs = CAL_DIV;
      end
      default: begin
        dvd = '0;
      end
    endcase
  end

  // Stage two: loaded divider input, high dividend bits as the first remainder.
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_tag    <= s1_tag;
      s2_div    <= dvs;
      s2_st.rem <= DIV_W'(dvd[DVD_W-1:SAMPLE_W]);
      s2_st.lo  <= dvd[SAMPLE_W-1:0];
      s2_st.q   <= '0;
    end
  end

  // Divider stages, two quotient bits each.
  always_ff @(posedge clk) begin
    if (adv) begin
      d_st[0]   <= div_step(div_step(s2_st, s2_div), s2_div);
      d_tag[0]  <= s2_tag;
      d_div[0]  <= s2_div;
      d_cell[0] <= s2_tag.cell_idx;
      for (int k = 1; k < DIV_STAGES; k++) begin
        d_st[k]   <= div_step(div_step(d_st[k-1], d_div[k-1]), d_div[k-1]);
        d_tag[k]  <= d_tag[k-1];
        d_div[k]  <= d_div[k-1];
        d_cell[k] <= d_cell[k-1];
      end
    end
  end

  // Stage valids.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      for (int k = 0; k < DIV_STAGES; k++) begin
        d_v[k] <= 1'b0;
      end
    end else if (adv) begin
      s1_v   <= issue;
      s2_v   <= s1_v;
      d_v[0] <= s2_v;
      for (int k = 1; k < DIV_STAGES; k++) begin
        d_v[k] <= d_v[k-1];
      end
    end
  end

  // Write-back: classify, build the new record and the result.
  tag_t                 wb_tag;
  rec_t                 wb_rec;
  logic [SAMPLE_W-1:0]  quo;
  logic signed [SAMPLE_W:0]   diff;
  logic [SAMPLE_W:0]          mag;
  logic signed [TRIG_W+1:0]   rel_th;
  logic [OCC_W-1:0]           pol;
  logic                       wb_v;

  assign wb_tag = d_tag[DIV_STAGES-1];
  assign wb_v   = d_v[DIV_STAGES-1];
  assign quo    = d_st[DIV_STAGES-1].q;

  always_comb begin
    wb_rec = wb_tag.rec;
    diff   = $signed({1'b0, quo}) - $signed({1'b0, wb_tag.rec.base});
    mag    = diff[SAMPLE_W] ? (SAMPLE_W+1)'(-diff) : diff;
    rel_th = $signed({2'b00, cfg.set_level}) - (TRIG_W+2)'(RELEASE_GAP);
    pol    = (diff > 0) ? OCC_POS : OCC_NEG;
    case (wb_tag.mode)
      MODE_DETECT: begin
        wb_rec.avg = quo;
        if (wb_tag.rec.occ == OCC_NONE) begin
          wb_rec.occ = (mag > {1'b0, cfg.set_level}) ? pol : OCC_NONE;
        end else if ($signed({1'b0, mag}) < rel_th) begin
          wb_rec.occ = OCC_NONE;
        end else begin
          wb_rec.occ = pol;
        end
      end
      MODE_FINISH: begin
        wb_rec.avg  = wb_tag.clamp ? SAMPLE_MAX : quo;
        wb_rec.base = wb_tag.clamp ? SAMPLE_MAX : quo;
        wb_rec.sum  = '0;
      end
      default: begin
        wb_rec = wb_tag.rec;
      end
    endcase
  end

  // Store update.
  always_ff @(posedge clk) begin
    if (adv && wb_v) begin
      mem[IW'(wb_tag.cell_idx)] <= wb_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CELLS; i++) begin
        cell_vld[i] <= 1'b0;
      end
    end else if (adv && wb_v) begin
      cell_vld[IW'(wb_tag.cell_idx)] <= 1'b1;
    end
  end

  // Raw cell index carried alongside for the echo.
  logic [CELL_W-1:0] raw_s1;
  logic [CELL_W-1:0] raw_s2;
  logic [CELL_W-1:0] raw_cell_q [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (issue) begin
      raw_s1 <= head.item.cell_index;
    end
    if (adv) begin
      raw_s2        <= raw_s1;
      raw_cell_q[0] <= raw_s2;
      for (int k = 1; k < DIV_STAGES; k++) begin
        raw_cell_q[k] <= raw_cell_q[k-1];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= wb_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && wb_v) begin
      out_item.cell_out   <= raw_cell_q[DIV_STAGES-1];
      out_item.cell_state <= wb_rec.occ;
      out_item.smoothed   <= wb_rec.avg;
      out_item.baseline   <= wb_rec.base;
    end
  end

  // The store-read and divider set-up stages never hold two items for one cell together.
  assert property (@(posedge clk) disable iff (rst)
    s1_v && s2_v |-> s1_cell != s2_tag.cell_idx)
    else $error("two items for one cell in the first stages");

  // An item leaves the queue only when one is there.
  assert property (@(posedge clk) disable iff (rst) pop |-> head.valid)
    else $error("queue popped while empty");

  // A finish item loads average and baseline with the same value.
  assert property (@(posedge clk) disable iff (rst)
    wb_v && wb_tag.mode == MODE_FINISH |-> wb_rec.avg == wb_rec.base)
    else $error("finish item left average and baseline apart");

  // A held output keeps the pipe frozen.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(s1_v) && $stable(s2_v))
    else $error("pipe moved while the output was held");

endmodule

>>> sv/sensor_grid_hysteresis_classifier_top.sv
// Channel | Handshake             | Payload
// input   | in_valid / in_stall   | in_item: mode, cell_index, sample
// output  | out_valid / out_stall | out_item: cell_out, cell_state, smoothed, baseline
// config  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One item is taken per cycle while the queue has room; once it leaves the queue,
// it passes store read, divider set-up, six divider stages and an output register.
// Items for a cell already in the pipe wait until its earlier item writes back.
// Reset clears the queue, the pipe valids and the per-cell written flags.
// A stalled output freezes the pipe; the four-slot input queue keeps taking items.
module sensor_grid_hysteresis_classifier_top
  import sgh_pkg::*;
#(
  parameter int CELLS     = 64,
  parameter int CAL_SCANS = 2000
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t  cfg;
  head_t head;
  logic  pop;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.set_level     <= TRIG_W'(25);
      cfg.alpha_divisor <= ALPHA_W'(8);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TRIGGER: cfg.set_level     <= cfg_data[TRIG_W-1:0];
        CFG_ALPHA:   cfg.alpha_divisor <= cfg_data[ALPHA_W-1:0];
        default:     cfg <= cfg;
      endcase
    end
  end

  sgh_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .pop      (pop),
    .head     (head)
  );

  sgh_back #(
    .CELLS     (CELLS),
    .CAL_SCANS (CAL_SCANS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

>>> tb/sensor_grid_hysteresis_classifier_top_test.sv
`timescale 1ns / 1ps

module sensor_grid_hysteresis_classifier_top_test;
  import sgh_pkg::*;

  localparam int NCELLS    = 64;
  localparam int SCANS     = 2000;
  localparam int CYCLE_MAX = 400000;

  // Ports of the block.
  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_item;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_item;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  sensor_grid_hysteresis_classifier_top #(.CELLS(NCELLS), .CAL_SCANS(SCANS)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Shadow copy of the grid state and registers.
  logic [SAMPLE_W-1:0] avg_mirror [NCELLS];
  logic [SAMPLE_W-1:0] base_mirror [NCELLS];
  logic [OCC_W-1:0]    occ_mirror [NCELLS];
  int unsigned         sum_mirror [NCELLS];
  int unsigned         trig_now;
  int unsigned         alpha_now;

  in_item_t  pending_samples [$];
  out_item_t expected_reports [$];
  int        send_gap_pct;
  int        recv_stall_pct;
  int        errors;
  int        cycles;

  // Works out the report of one accepted sample and updates the shadow state.
  function automatic out_item_t classify_sample(in_item_t it);
    out_item_t   r;
    int unsigned c;
    int unsigned n;
    int unsigned a;
    int unsigned q;
    int          diff;
    int          mag;
    int          rel;
    logic [OCC_W-1:0] pol;
    c = it.cell_index % NCELLS;
    if (it.mode == MODE_DETECT) begin
      n = (alpha_now == 0) ? 1 : alpha_now;
      a = (it.sample + (n - 1) * avg_mirror[c]) / n;
      if (a > SAMPLE_MAX) a = SAMPLE_MAX;
      avg_mirror[c] = SAMPLE_W'(a);
      diff = int'(a) - int'(base_mirror[c]);
      mag = diff < 0 ? -diff : diff;
      rel = int'(trig_now) - RELEASE_GAP;
      pol = diff > 0 ? OCC_POS : OCC_NEG;
      if (occ_mirror[c] == OCC_NONE)
        occ_mirror[c] = (mag > int'(trig_now)) ? pol : OCC_NONE;
      else if (mag < rel)
        occ_mirror[c] = OCC_NONE;
      else
        occ_mirror[c] = pol;
    end else if (it.mode == MODE_ACCUM) begin
      sum_mirror[c] = sum_mirror[c] + it.sample;
      if (sum_mirror[c] > (1 << 23) - 1) sum_mirror[c] = (1 << 23) - 1;
    end else if (it.mode == MODE_FINISH) begin
      q = sum_mirror[c] / SCANS;
      if (q > SAMPLE_MAX) q = SAMPLE_MAX;
      base_mirror[c] = SAMPLE_W'(q);
      avg_mirror[c] = SAMPLE_W'(q);
      sum_mirror[c] = 0;
    end
    r.cell_out   = it.cell_index;
    r.cell_state = occ_mirror[c];
    r.smoothed   = avg_mirror[c];
    r.baseline   = base_mirror[c];
    return r;
  endfunction

  // Driver: presents queued items, holding each until it is taken.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_reports.push_back(classify_sample(in_item));
      end
      if (!in_valid || !in_stall) begin
        if (pending_samples.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
          in_item  <= pending_samples.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each report against the oldest expectation.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          $display("%0t unexpected report: actual %h", $time, out_item);
          errors++;
        end else begin
          out_item_t e;
          e = expected_reports.pop_front();
          if (e.cell_out !== out_item.cell_out)
            $display("%0t cell_out: expected %0d actual %0d", $time, e.cell_out,
                     out_item.cell_out);
          if (e.cell_state !== out_item.cell_state)
            $display("%0t cell_state: expected %0d actual %0d", $time, e.cell_state,
                     out_item.cell_state);
          if (e.smoothed !== out_item.smoothed)
            $display("%0t smoothed: expected %0d actual %0d", $time, e.smoothed,
                     out_item.smoothed);
          if (e.baseline !== out_item.baseline)
            $display("%0t baseline: expected %0d actual %0d", $time, e.baseline,
                     out_item.baseline);
          if (e !== out_item) errors++;
        end
      end
    end
  end

  // Timeout guard.
  always @(posedge clk) begin
    if (cycles > CYCLE_MAX) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic in_item_t make_sample(logic [MODE_W-1:0] m, int unsigned c,
                                           int unsigned s);
    in_item_t it;
    it.mode       = m;
    it.cell_index = CELL_W'(c);
    it.sample     = SAMPLE_W'(s);
    return it;
  endfunction

  // Waits until every queued item has been sent and every report has come.
  task automatic drain();
    while (pending_samples.size() > 0 || in_valid || expected_reports.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_TRIGGER) trig_now = val & 12'hFFF;
    else alpha_now = val & 8'hFF;
  endtask

  // Random phase: mostly detect sweeps around the baseline, plus accumulate
  // and finish items on a few cells and some noise.
  task automatic random_phase(int count);
    int unsigned c;
    int unsigned lvl;
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(9))
        0: pending_samples.push_back(make_sample(MODE_W'($urandom_range(3)),
                                                 $urandom_range(63),
                                                 $urandom_range(4095)));
        1: pending_samples.push_back(make_sample(MODE_ACCUM, $urandom_range(3),
                                                 $urandom_range(4095)));
        2: pending_samples.push_back(make_sample(MODE_FINISH, $urandom_range(3),
                                                 $urandom_range(4095)));
        default: begin
          c = $urandom_range(7);
          lvl = $urandom_range(1) ? $urandom_range(1800, 2200) : $urandom_range(4095);
          pending_samples.push_back(make_sample(MODE_DETECT, c, lvl));
        end
      endcase
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_TRIGGER;
    cfg_data = '0;
    errors = 0;
    cycles = 0;
    send_gap_pct = 0;
    recv_stall_pct = 0;
    trig_now = 25;
    alpha_now = 8;
    for (int i = 0; i < NCELLS; i++) begin
      avg_mirror[i] = '0;
      base_mirror[i] = default_baseline(CELL_W'(i));
      occ_mirror[i] = OCC_NONE;
      sum_mirror[i] = 0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, every mode, finish with a clear sum.
    pending_samples.push_back(make_sample(MODE_DETECT, 0, 0));
    pending_samples.push_back(make_sample(MODE_DETECT, 63, 4095));
    pending_samples.push_back(make_sample(MODE_DETECT, 63, 4095));
    pending_samples.push_back(make_sample(2'd3, 5, 4095));
    pending_samples.push_back(make_sample(MODE_FINISH, 9, 4095));
    for (int i = 0; i < 4; i++)
      pending_samples.push_back(make_sample(MODE_ACCUM, 1, 4095));
    pending_samples.push_back(make_sample(MODE_FINISH, 1, 0));
    drain();

    // Zero divisor and low trigger level: held cells are never released.
    write_reg(CFG_ALPHA, 0);
    write_reg(CFG_TRIGGER, 0);
    pending_samples.push_back(make_sample(MODE_DETECT, 2, 4095));
    pending_samples.push_back(make_sample(MODE_DETECT, 2, 2033));
    pending_samples.push_back(make_sample(MODE_DETECT, 2, 0));
    pending_samples.push_back(make_sample(MODE_DETECT, 2, 2033));
    drain();
    write_reg(CFG_ALPHA, 255);
    write_reg(CFG_TRIGGER, 4095);
    pending_samples.push_back(make_sample(MODE_DETECT, 3, 4095));
    pending_samples.push_back(make_sample(MODE_DETECT, 3, 4095));
    drain();

    // A short calibration run on one cell, then filter with N of one.
    write_reg(CFG_ALPHA, 1);
    write_reg(CFG_TRIGGER, 25);
    for (int i = 0; i < 40; i++)
      pending_samples.push_back(make_sample(MODE_ACCUM, 4, 4095));
    pending_samples.push_back(make_sample(MODE_FINISH, 4, 0));
    pending_samples.push_back(make_sample(MODE_DETECT, 4, 0));
    pending_samples.push_back(make_sample(MODE_DETECT, 4, 4095));
    drain();

    // Random phases with differing idling and settings.
    send_gap_pct = 31;
    recv_stall_pct = 86;
    write_reg(CFG_ALPHA, 8);
    write_reg(CFG_TRIGGER, 25);
    random_phase(230);
    drain();
    send_gap_pct = 86;
    recv_stall_pct = 31;
    write_reg(CFG_ALPHA, 2);
    write_reg(CFG_TRIGGER, 5);
    random_phase(230);
    drain();
    send_gap_pct = 0;
    recv_stall_pct = 0;
    write_reg(CFG_ALPHA, $urandom_range(1, 255));
    write_reg(CFG_TRIGGER, $urandom_range(0, 4095) & 12'h0FF);
    random_phase(230);
    drain();

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
